/* src/decimal_amount_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal amount parser
// Implication checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_AMOUNT_PARSER_ASSERT_SVH
`define DECIMAL_AMOUNT_PARSER_ASSERT_SVH

// Same-cycle implication.
`define DAP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dap_pkg.sv */
// ----------------------------------------------------------------------------
// dap_pkg
// Status codes, character codes and the power-of-ten table for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dap_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_BADCHAR     = 3'd1;
    localparam status_t ST_NOPOINT     = 3'd2;
    localparam status_t ST_TWOPOINTS   = 3'd3;
    localparam status_t ST_TOOMANYFRAC = 3'd4;
    localparam status_t ST_OVERFLOW    = 3'd5;

    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] MAX_PLACES = 4'd9;
    localparam int POW10_WIDTH = 30;

    typedef logic [POW10_WIDTH-1:0] pow10_t;

    function automatic pow10_t pow10(input logic [3:0] k);
        pow10_t r;
        case (k)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/decimal_amount_parser.sv */
// ----------------------------------------------------------------------------
// decimal_amount_parser
// Turns an ASCII decimal amount into a count of smallest currency units.
// ----------------------------------------------------------------------------
// The input stream carries one ASCII character per word on s_tdata, with
// s_tlast marking the final character of an amount. An optional leading '+'
// is followed by digits and at most one point; fraction_digits (APB, byte
// address 0, reset value 2) sets the number of decimal places.
// One result word leaves on the output stream for every last character:
// the amount on m_tdata and the status code on m_tuser. The first error of
// a string is held and the rest of that string is ignored.
// One character is taken every cycle while s_tready is high. Characters
// update the running value as they arrive; the final character loads a
// scaling stage whose single multiplier scales by a power of ten, and
// the result register then takes the scaled word for the output stream.
// Reset clears the string state and both pipeline stages and sets
// fraction_digits to 2. When the receiver stalls, the result register and
// the scaling stage hold their words and s_tready falls only once both are
// full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_amount_parser_assert.svh"

module decimal_amount_parser
    import dap_pkg::*;
#(
    parameter int unsigned AMOUNT_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream: tdata [7:0] char_code; tlast last_char.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // Output stream: tdata [31:0] amount; tuser [2:0] status.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic [2:0]       m_tuser,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = AMOUNT_WIDTH;
    localparam int PW = AW + POW10_WIDTH;

    // Configuration.
    logic [3:0] frac_digits_reg;
    logic       cfg_write;

    // String state.
    logic [AW-1:0] value_reg, value_next;
    logic          point_reg, point_next;
    logic [3:0]    fcount_reg, fcount_next;
    status_t       err_reg, err_next;
    logic          start_reg;

    // Scaling stage.
    logic          sc_valid_reg;
    logic [AW-1:0] sc_value_reg;
    logic [3:0]    sc_shift_reg;
    status_t       sc_err_reg;

    // Result register.
    logic          out_valid_reg;
    logic [31:0]   out_amount_reg;
    status_t       out_status_reg;

    logic          in_accept;
    logic          sc_advance;
    logic [3:0]    places;
    logic          is_digit;
    logic          skip;
    logic [AW+3:0] value_ext;
    logic [AW+3:0] times_ten;
    logic [3:0]    shift;
    logic [PW-1:0] product;
    logic          scale_ovf;
    status_t       final_status;
    logic [AW+31:0] amount_ext;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = {28'd0, frac_digits_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_digits_reg <= 4'd2;
        end
        else if (cfg_write)
        begin
            frac_digits_reg <= pwdata[3:0];
        end
    end

    // Handshakes.
    assign sc_advance = !out_valid_reg || m_tready;
    assign s_tready   = !sc_valid_reg || sc_advance;
    assign in_accept  = s_tvalid && s_tready;

    // Per-character update.
    assign places    = (frac_digits_reg > MAX_PLACES) ? MAX_PLACES : frac_digits_reg;
    assign is_digit  = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign skip      = (err_reg != ST_OK) || (start_reg && s_tdata == CHAR_PLUS);
    assign value_ext = {4'd0, value_reg};
    // value*10 + digit; any bit above the amount width means overflow.
    assign times_ten = (value_ext << 3) + (value_ext << 1) + {{AW{1'b0}}, s_tdata[3:0]};

    always_comb
    begin
        value_next  = value_reg;
        point_next  = point_reg;
        fcount_next = fcount_reg;
        err_next    = err_reg;
        if (!skip)
        begin
            if (s_tdata == CHAR_DOT)
            begin
                if (places == 4'd0)
                    err_next = ST_NOPOINT;
                else if (point_reg)
                    err_next = ST_TWOPOINTS;
                else
                    point_next = 1'b1;
            end
            else if (!is_digit)
            begin
                err_next = ST_BADCHAR;
            end
            else if (point_reg && ({1'b0, fcount_reg} + 5'd1 > {1'b0, places}))
            begin
                err_next = ST_TOOMANYFRAC;
            end
            else
            begin
                if (point_reg)
                    fcount_next = fcount_reg + 4'd1;
                if (times_ten[AW+3:AW] != 4'd0)
                    err_next = ST_OVERFLOW;
                else
                    value_next = times_ten[AW-1:0];
            end
        end
    end

    // Missing fraction digits, applied by the scaling stage.
    assign shift = (err_next == ST_OK && fcount_next < places) ? places - fcount_next : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            point_reg  <= 1'b0;
            fcount_reg <= 4'd0;
            err_reg    <= ST_OK;
            start_reg  <= 1'b1;
        end
        else if (in_accept)
        begin
            if (s_tlast)
            begin
                value_reg  <= '0;
                point_reg  <= 1'b0;
                fcount_reg <= 4'd0;
                err_reg    <= ST_OK;
                start_reg  <= 1'b1;
            end
            else
            begin
                value_reg  <= value_next;
                point_reg  <= point_next;
                fcount_reg <= fcount_next;
                err_reg    <= err_next;
                start_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (in_accept && s_tlast)
        begin
            sc_valid_reg <= 1'b1;
        end
        else if (sc_advance)
        begin
            sc_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tlast)
        begin
            sc_value_reg <= value_next;
            sc_shift_reg <= shift;
            sc_err_reg   <= err_next;
        end
    end

    // Final scaling by a power of ten, with an exact overflow check.
    assign product    = {{POW10_WIDTH{1'b0}}, sc_value_reg} * {{AW{1'b0}}, pow10(sc_shift_reg)};
    assign scale_ovf  = (product[PW-1:AW] != '0);
    assign amount_ext = {32'd0, product[AW-1:0]};

    always_comb
    begin
        if (sc_err_reg != ST_OK)
            final_status = sc_err_reg;
        else if (scale_ovf)
            final_status = ST_OVERFLOW;
        else
            final_status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sc_advance)
        begin
            out_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_advance && sc_valid_reg)
        begin
            out_status_reg <= final_status;
            out_amount_reg <= (final_status == ST_OK) ? amount_ext[31:0] : 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_amount_reg;
    assign m_tuser  = out_status_reg;

    `DAP_ASSERT_SAME(a_err_amount_zero, m_tvalid && m_tuser != ST_OK, m_tdata == 32'd0,
        "Result word with an error status carries a non-zero amount")
    `DAP_ASSERT_SAME(a_status_range, m_tvalid, m_tuser <= ST_OVERFLOW,
        "Result word carries an undefined status code")
    `DAP_ASSERT_NEXT(a_scale_hold, sc_valid_reg && out_valid_reg && !m_tready,
        sc_valid_reg && $stable(sc_value_reg) && $stable(sc_shift_reg),
        "Scaling stage lost its word while the output was stalled")
    `DAP_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, s_tready,
        "Input stalled although the result register is empty")
    `DAP_ASSERT_NEXT(a_last_clears, in_accept && s_tlast,
        start_reg && err_reg == ST_OK && value_reg == '0,
        "String state not cleared after the last character")

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for decimal_amount_parser
// Feeds ASCII amount strings one character per word, predicts each result
// word in step with every accepted character, and compares the amount and
// status of every result word in order. A short directed table comes first.
// Random strings then run under several fraction settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import dap_pkg::*;

    localparam int unsigned AMT_W           = 32;
    localparam logic [63:0] AMT_MAX         = (64'd1 << AMT_W) - 64'd1;
    localparam logic [2:0]  ADDR_FRAC_DIGITS = 3'd0;
    localparam int          STALL_LIMIT     = 5000;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          ITEMS_PER_PHASE = 120;

    typedef struct packed {
        logic [31:0] amount;
        status_t     status;
    } amount_word_t;

    typedef enum logic [1:0] {ROW_CHAR, ROW_CHECKED, ROW_WRITE} row_kind_t;

    // For ROW_WRITE the low four bits of chr carry the new fraction setting.
    typedef struct packed {
        row_kind_t    kind;
        logic [7:0]   chr;
        logic         lst;
        amount_word_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] amount
    logic [2:0]  m_tuser;            // [2:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    logic [3:0]  places_reg = 4'd2;
    logic [63:0] acc_value  = 64'd0;
    logic        dot_seen   = 1'b0;
    logic [3:0]  frac_taken = 4'd0;
    status_t     first_err  = ST_OK;
    logic        at_first   = 1'b1;

    amount_word_t amount_q[$];
    logic [7:0]   text_q[$];

    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;
    bit           hold_go       = 1'b0;
    logic         cur_typed     = 1'b0;
    amount_word_t cur_want      = '0;

    int err_cnt     = 0;
    int n_chars     = 0;
    int n_results   = 0;
    int n_ok        = 0;
    int n_writes    = 0;
    int idle_cycles = 0;

    decimal_amount_parser #(.AMOUNT_WIDTH(AMT_W)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= 40)
        begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // Applies one character to the predicted parser state; a last character
    // yields the amount word and returns the state to the start of a string.
    task automatic parse_char(input logic [7:0] c, input logic lst,
                              output logic got, output amount_word_t res);
        logic [3:0]  places;
        logic [3:0]  n;
        logic [63:0] d;
        logic        first;
        places = (places_reg > MAX_PLACES) ? MAX_PLACES : places_reg;
        first  = at_first;
        at_first = 1'b0;
        got = 1'b0;
        res = '0;
        if (first_err == ST_OK && !(first && c == CHAR_PLUS))
        begin
            if (c == CHAR_DOT)
            begin
                // The zero-places check wins over the second-point check.
                if (places == 4'd0)
                    first_err = ST_NOPOINT;
                else if (dot_seen)
                    first_err = ST_TWOPOINTS;
                else
                    dot_seen = 1'b1;
            end
            else if (c < CHAR_ZERO || c > CHAR_NINE)
                first_err = ST_BADCHAR;
            else if (dot_seen && frac_taken >= places)
                first_err = ST_TOOMANYFRAC;
            else
            begin
                if (dot_seen)
                    frac_taken = frac_taken + 4'd1;
                d = 64'(c - CHAR_ZERO);
                if (acc_value > (AMT_MAX - d) / 64'd10)
                    first_err = ST_OVERFLOW;
                else
                    acc_value = acc_value * 64'd10 + d;
            end
        end
        if (lst)
        begin
            n = frac_taken;
            while (first_err == ST_OK && n < places)
            begin
                if (acc_value > AMT_MAX / 64'd10)
                    first_err = ST_OVERFLOW;
                else
                    acc_value = acc_value * 64'd10;
                n = n + 4'd1;
            end
            got = 1'b1;
            if (first_err == ST_OK)
                res.amount = acc_value[31:0];
            res.status = first_err;
            acc_value  = 64'd0;
            dot_seen   = 1'b0;
            frac_taken = 4'd0;
            first_err  = ST_OK;
            at_first   = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        logic         got;
        amount_word_t pred;
        amount_word_t want;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                moved = 1'b1;
                if (paddr == ADDR_FRAC_DIGITS)
                    places_reg = pwdata[3:0];
            end
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                n_chars++;
                parse_char(s_tdata, s_tlast, got, pred);
                if (got)
                    amount_q.push_back(cur_typed ? cur_want : pred);
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                n_results++;
                if (m_tuser == ST_OK)
                    n_ok++;
                if (amount_q.size() == 0)
                    report_mismatch($sformatf("result word %0d / status %0d with none expected",
                                              m_tdata, m_tuser));
                else
                begin
                    want = amount_q.pop_front();
                    if (m_tdata !== want.amount)
                        report_mismatch($sformatf("amount %0d, expected %0d",
                                                  m_tdata, want.amount));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when asked for.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Called and returns at a falling edge.
    task automatic send_char(input logic [7:0] c, input logic lst,
                             input logic typed, input amount_word_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        cur_typed = typed;
        cur_want  = want;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (amount_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_places(input logic [3:0] v);
        logic [31:0] rnd;
        rnd = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FRAC_DIGITS;
        pwdata  <= {rnd[31:4], v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
        // The register reads back the four bits just written.
        if (prdata !== {28'd0, v})
            report_mismatch($sformatf("read back %0d, expected %0d", prdata, v));
    endtask

    // Builds one random amount string in text_q for the given decimal places.
    task automatic build_amount_text(input logic [3:0] places);
        int          pick;
        int          n;
        int          k;
        int          idx;
        logic [63:0] v;
        text_q.delete();
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            // Wide values, many of them right at the top of the amount range.
            if ($urandom_range(1) == 1)
                v = AMT_MAX + 64'd3 - 64'($urandom_range(6));
            else
                v = 64'($urandom);
            if (places == 4'd0)
                k = 0;
            else if ($urandom_range(3) == 0)
                k = $urandom_range(places);
            else
                k = places;
            n = 0;
            while (n == 0 || v != 0 || n < k)
            begin
                text_q.push_front(8'(CHAR_ZERO + v % 64'd10));
                v = v / 64'd10;
                n++;
                if (n == k)
                    text_q.push_front(CHAR_DOT);
            end
        end
        else if (pick < 90)
        begin
            n = $urandom_range(3);
            repeat (n)
                text_q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            if ((places != 4'd0 && $urandom_range(1) == 1) || $urandom_range(9) == 0)
            begin
                text_q.push_back(CHAR_DOT);
                k = ($urandom_range(9) == 0) ? places + 1 : $urandom_range(places);
                repeat (k)
                    text_q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            end
            if (text_q.size() == 0)
                text_q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            if (pick >= 70)
            begin
                idx = $urandom_range(text_q.size() - 1);
                case ($urandom_range(2))
                    0:       text_q[idx] = CHAR_PLUS;
                    1:       text_q[idx] = CHAR_DOT;
                    default: text_q[idx] = 8'($urandom_range(255));
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                text_q.push_back(8'($urandom_range(255)));
        end
        if (pick < 90 && $urandom_range(4) == 0)
            text_q.push_front(CHAR_PLUS);
    endtask

    function automatic dir_row_t char_row(input logic [7:0] c, input logic lst);
        dir_row_t r;
        r.kind = ROW_CHAR;
        r.chr  = c;
        r.lst  = lst;
        r.want = '0;
        return r;
    endfunction

    function automatic dir_row_t checked_row(input logic [7:0] c, input logic [31:0] amt,
                                             input status_t st);
        dir_row_t r;
        r.kind        = ROW_CHECKED;
        r.chr         = c;
        r.lst         = 1'b1;
        r.want.amount = amt;
        r.want.status = st;
        return r;
    endfunction

    function automatic dir_row_t write_row(input logic [3:0] v);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.chr  = {4'd0, v};
        return r;
    endfunction

    initial
    begin : stimulus
        dir_row_t    dir_tab[$];
        logic [3:0]  places;
        logic [3:0]  gen_places;
        int          sent;
        bit          paused;

        // Two places from reset.
        dir_tab.push_back(checked_row(CHAR_PLUS, 32'd0, ST_OK));
        dir_tab.push_back(char_row(CHAR_PLUS, 1'b0));
        dir_tab.push_back(char_row("1", 1'b0));
        dir_tab.push_back(char_row(CHAR_DOT, 1'b0));
        dir_tab.push_back(char_row("5", 1'b1));
        dir_tab.push_back(char_row("1", 1'b0));
        dir_tab.push_back(checked_row(CHAR_PLUS, 32'd0, ST_BADCHAR));
        dir_tab.push_back(checked_row(8'h00, 32'd0, ST_BADCHAR));
        dir_tab.push_back(checked_row(8'hFF, 32'd0, ST_BADCHAR));
        dir_tab.push_back(char_row(CHAR_DOT, 1'b0));
        dir_tab.push_back(checked_row(CHAR_DOT, 32'd0, ST_TWOPOINTS));
        dir_tab.push_back(char_row(CHAR_DOT, 1'b0));
        dir_tab.push_back(char_row("1", 1'b0));
        dir_tab.push_back(char_row("2", 1'b0));
        dir_tab.push_back(checked_row("3", 32'd0, ST_TOOMANYFRAC));
        dir_tab.push_back(write_row(4'd0));
        dir_tab.push_back(checked_row(CHAR_DOT, 32'd0, ST_NOPOINT));
        // Fifteen places behave as nine.
        dir_tab.push_back(write_row(4'd15));
        dir_tab.push_back(checked_row("4", 32'd4000000000, ST_OK));
        dir_tab.push_back(checked_row("5", 32'd0, ST_OVERFLOW));
        // The setting drops below the fraction digits already taken.
        dir_tab.push_back(write_row(4'd3));
        dir_tab.push_back(char_row("9", 1'b0));
        dir_tab.push_back(char_row(CHAR_DOT, 1'b0));
        dir_tab.push_back(char_row("1", 1'b0));
        dir_tab.push_back(char_row("2", 1'b0));
        dir_tab.push_back(write_row(4'd1));
        dir_tab.push_back(checked_row("3", 32'd0, ST_TOOMANYFRAC));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_places(dir_tab[i].chr[3:0]);
            end
            else
                send_char(dir_tab[i].chr, dir_tab[i].lst, dir_tab[i].kind == ROW_CHECKED,
                          dir_tab[i].want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    places = 4'd9;
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    places = 4'd0;
                    src_idle_pct = 77;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    places = 4'($urandom_range(1, 15));
                    src_idle_pct = 0;
                    snk_stall_pct = 77;
                end
                default:
                begin
                    places = 4'd15;
                    src_idle_pct = 15;
                    snk_stall_pct = 15;
                end
            endcase
            write_places(places);
            gen_places = (places > MAX_PLACES) ? MAX_PLACES : places;
            // Full-rate characters against a held-off receiver fill the block.
            if (ph == 0)
                hold_go = 1'b1;
            sent   = 0;
            paused = 1'b0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (ph == 3 && !paused && sent >= ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                build_amount_text(gen_places);
                foreach (text_q[j])
                    send_char(text_q[j], j == text_q.size() - 1, 1'b0, '0);
                sent += text_q.size();
            end
        end
        wait_drained();

        $display("Sent %0d characters and checked %0d result words (%0d ok, %0d refused).",
                 n_chars, n_results, n_ok, n_results - n_ok);
        $display("Fraction setting written %0d times, with 0, 9, 15 and a change mid-string.",
                 n_writes);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/dap_pkg.sv
src/decimal_amount_parser.sv
sim/tb.sv
